[design/trilat_pkg.sv]
// Shared widths, types and helpers for the four-anchor trilateration core.
package trilat_pkg;

  localparam int unsigned DEFAULT_COORD_BITS = 16;
  localparam int unsigned CW = 16;   // anchor coordinate and range width
  localparam int unsigned AXW = 48;  // packed anchor register width
  localparam int unsigned MW = 17;   // matrix entry (coordinate difference)
  localparam int unsigned SQW = 32;  // square of a coordinate
  localparam int unsigned RQW = 33;  // square of a range
  localparam int unsigned SSW = 33;  // sum of three coordinate squares
  localparam int unsigned WW = 34;   // right-hand side term
  localparam int unsigned PW = 34;   // product of two matrix entries
  localparam int unsigned JW = 35;   // adjugate entry
  localparam int unsigned DPW = 52;  // product in the determinant
  localparam int unsigned DTW = 54;  // determinant
  localparam int unsigned DNW = 55;  // twice the determinant
  localparam int unsigned NPW = 69;  // adjugate times right-hand side
  localparam int unsigned NW = 71;   // numerator
  localparam int unsigned RW = 72;   // divider remainder
  localparam int unsigned OW = 16;   // output coordinate width
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 64;

  typedef logic [AXW-1:0] anchor_t;

  typedef struct packed {
    logic [NW-1:0]  nabs;
    logic           neg;
  } num_t;

  typedef struct packed {
    num_t [2:0]     num;
    logic [DNW-1:0] dabs;
    logic           sing;
  } geo_t;

  function automatic logic signed [CW-1:0] coord_of(anchor_t a, int unsigned c);
    return $signed(a[CW*c +: CW]);
  endfunction

endpackage

[design/trilat_geom.sv]
// Six-stage front end: matrix, adjugate, determinant and numerators.
module trilat_geom (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  trilat_pkg::anchor_t         anchor_i [4],
  input  logic [trilat_pkg::CW-1:0]   range_i [4],
  output trilat_pkg::geo_t            geo_o
);
  import trilat_pkg::*;

  logic signed [MW-1:0]  m1_q [3][3];
  logic signed [RQW-1:0] rsq1_q [4];
  logic signed [SQW-1:0] csq1_q [4][3];

  logic signed [MW-1:0]  m2_q [3][3];
  logic signed [WW-1:0]  w2_q [3];
  logic signed [PW-1:0]  pa2_q [3][3];
  logic signed [PW-1:0]  pb2_q [3][3];

  logic signed [MW-1:0]  m3_q [3][3];
  logic signed [WW-1:0]  w3_q [3];
  logic signed [JW-1:0]  adj3_q [3][3];

  logic signed [DPW-1:0] dp4_q [3];
  logic signed [NPW-1:0] np4_q [3][3];

  logic signed [DTW-1:0] det5_q;
  logic signed [NW-1:0]  num5_q [3];

  geo_t geo_q;

  logic signed [SSW-1:0] sq_d [4];
  logic signed [DNW-1:0] den_d;
  logic signed [NW-1:0]  nneg_d [3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sq_d[k] = SSW'(csq1_q[k][0]) + SSW'(csq1_q[k][1]) + SSW'(csq1_q[k][2]);
    end
    den_d = DNW'(det5_q) <<< 1;
    for (int k = 0; k < 3; k++) begin
      nneg_d[k] = -num5_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        rsq1_q[k] <= RQW'($signed({1'b0, range_i[k]})) * RQW'($signed({1'b0, range_i[k]}));
        for (int c = 0; c < 3; c++) begin
          csq1_q[k][c] <= SQW'(coord_of(anchor_i[k], c)) * SQW'(coord_of(anchor_i[k], c));
        end
      end
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 3; c++) begin
          m1_q[k][c] <= MW'(coord_of(anchor_i[k+1], c)) - MW'(coord_of(anchor_i[0], c));
        end
      end

      m2_q <= m1_q;
      for (int k = 0; k < 3; k++) begin
        w2_q[k] <= WW'(rsq1_q[0]) - WW'(rsq1_q[k+1]) + WW'(sq_d[k+1]) - WW'(sq_d[0]);
      end
      pa2_q[0][0] <= PW'(m1_q[1][1]) * PW'(m1_q[2][2]);
      pb2_q[0][0] <= PW'(m1_q[1][2]) * PW'(m1_q[2][1]);
      pa2_q[0][1] <= PW'(m1_q[0][2]) * PW'(m1_q[2][1]);
      pb2_q[0][1] <= PW'(m1_q[0][1]) * PW'(m1_q[2][2]);
      pa2_q[0][2] <= PW'(m1_q[0][1]) * PW'(m1_q[1][2]);
      pb2_q[0][2] <= PW'(m1_q[0][2]) * PW'(m1_q[1][1]);
      pa2_q[1][0] <= PW'(m1_q[1][2]) * PW'(m1_q[2][0]);
      pb2_q[1][0] <= PW'(m1_q[1][0]) * PW'(m1_q[2][2]);
      pa2_q[1][1] <= PW'(m1_q[0][0]) * PW'(m1_q[2][2]);
      pb2_q[1][1] <= PW'(m1_q[0][2]) * PW'(m1_q[2][0]);
      pa2_q[1][2] <= PW'(m1_q[0][2]) * PW'(m1_q[1][0]);
      pb2_q[1][2] <= PW'(m1_q[0][0]) * PW'(m1_q[1][2]);
      pa2_q[2][0] <= PW'(m1_q[1][0]) * PW'(m1_q[2][1]);
      pb2_q[2][0] <= PW'(m1_q[1][1]) * PW'(m1_q[2][0]);
      pa2_q[2][1] <= PW'(m1_q[0][1]) * PW'(m1_q[2][0]);
      pb2_q[2][1] <= PW'(m1_q[0][0]) * PW'(m1_q[2][1]);
      pa2_q[2][2] <= PW'(m1_q[0][0]) * PW'(m1_q[1][1]);
      pb2_q[2][2] <= PW'(m1_q[0][1]) * PW'(m1_q[1][0]);

      m3_q <= m2_q;
      w3_q <= w2_q;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          adj3_q[r][c] <= JW'(pa2_q[r][c]) - JW'(pb2_q[r][c]);
        end
      end

      for (int c = 0; c < 3; c++) begin
        dp4_q[c] <= DPW'(m3_q[0][c]) * DPW'(adj3_q[c][0]);
      end
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          np4_q[k][i] <= NPW'(adj3_q[k][i]) * NPW'(w3_q[i]);
        end
      end

      det5_q <= DTW'(dp4_q[0]) + DTW'(dp4_q[1]) + DTW'(dp4_q[2]);
      for (int k = 0; k < 3; k++) begin
        num5_q[k] <= NW'(np4_q[k][0]) + NW'(np4_q[k][1]) + NW'(np4_q[k][2]);
      end

      geo_q.sing <= (det5_q == '0);
      geo_q.dabs <= den_d[DNW-1] ? DNW'(-den_d) : DNW'(den_d);
      for (int k = 0; k < 3; k++) begin
        geo_q.num[k].nabs <= num5_q[k][NW-1] ? NW'(nneg_d[k]) : NW'(num5_q[k]);
        geo_q.num[k].neg  <= num5_q[k][NW-1] ^ det5_q[DTW-1];
      end
    end
  end

  assign geo_o = geo_q;

endmodule

[design/trilat_div_lane.sv]
// Pipelined restoring divider lane with saturation check, one quotient bit a stage.
module trilat_div_lane #(
  parameter int unsigned SAT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  trilat_pkg::num_t             num_i,
  input  logic [trilat_pkg::DNW-1:0]   dabs_i,
  output logic [SAT_BITS-1:0]          quot_o,
  output logic                         neg_o,
  output logic                         clip_o
);
  import trilat_pkg::*;

  logic [RW-1:0]       rem_q  [SAT_BITS+1];
  logic [DNW-1:0]      den_q  [SAT_BITS+1];
  logic [SAT_BITS-1:0] quot_q [SAT_BITS+1];
  logic                neg_q  [SAT_BITS+1];
  logic                clip_q [SAT_BITS+1];

  logic [RW-1:0] lim_d;
  logic [RW-1:0] bound_d;

  always_comb begin
    lim_d   = RW'(dabs_i) << (SAT_BITS - 1);
    bound_d = num_i.neg ? lim_d + RW'(dabs_i) : lim_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= RW'(num_i.nabs);
      den_q[0]  <= dabs_i;
      quot_q[0] <= '0;
      neg_q[0]  <= num_i.neg;
      clip_q[0] <= (RW'(num_i.nabs) >= bound_d);
    end
  end

  for (genvar j = 1; j <= SAT_BITS; j++) begin : g_step
    localparam int unsigned BIT = SAT_BITS - j;
    logic [RW-1:0] trial;
    logic          take;
    assign trial = RW'(den_q[j-1]) << BIT;
    assign take  = (rem_q[j-1] >= trial);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= take ? rem_q[j-1] - trial : rem_q[j-1];
        den_q[j]  <= den_q[j-1];
        quot_q[j] <= quot_q[j-1] | (take ? SAT_BITS'(1) << BIT : '0);
        neg_q[j]  <= neg_q[j-1];
        clip_q[j] <= clip_q[j-1];
      end
    end
  end

  assign quot_o = quot_q[SAT_BITS];
  assign neg_o  = neg_q[SAT_BITS];
  assign clip_o = clip_q[SAT_BITS];

endmodule

[design/four_anchor_trilateration_core.sv]
// Top level of the four-anchor trilateration core: registers, pipeline control and output.
//
// The core turns four measured ranges (mm) to anchors A-D into a position in mm, by the
// exact solution of the linearized system, truncated toward zero and saturated to
// min(COORD_BITS,16) signed bits and sign-extended to 16 bits. A degenerate anchor set
// gives a zero position with singular set. One request enters per cycle while the core is
// not stalled; a result passes through the six-stage geometry front end, the divider lanes,
// which resolve one quotient bit per stage, and an output register. A stall on the output
// while a result is waiting freezes the whole pipeline. Anchor registers sit at byte addresses
// 0, 8, 16 and 24; the user must write them only while the core is idle, the core does not enforce it.
module four_anchor_trilateration_core #(
  parameter int unsigned COORD_BITS = trilat_pkg::DEFAULT_COORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [trilat_pkg::PADDR_W-1:0]    paddr,
  input  logic [trilat_pkg::PDATA_W-1:0]    pwdata,
  output logic [trilat_pkg::PDATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [15:0]                       range_a_i,
  input  logic [15:0]                       range_b_i,
  input  logic [15:0]                       range_c_i,
  input  logic [15:0]                       range_d_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [15:0]                pos_x_o,
  output logic signed [15:0]                pos_y_o,
  output logic signed [15:0]                pos_z_o,
  output logic                              singular_o,
  output logic                              clipped_o
);
  import trilat_pkg::*;

  localparam int unsigned SAT_BITS = (COORD_BITS < OW) ? COORD_BITS : OW;
  localparam int unsigned GEO_LAT = 6;
  localparam int unsigned DIV_LAT = SAT_BITS + 1;
  localparam int unsigned LAT = GEO_LAT + DIV_LAT + 1;

  anchor_t           anchor_q [4];
  logic [CW-1:0]     range_d [4];
  logic [LAT-1:0]    vld_q;
  logic [DIV_LAT-1:0] sing_q;
  logic              en;
  geo_t              geo;

  logic [SAT_BITS-1:0] quot [3];
  logic                neg  [3];
  logic                clip [3];
  logic signed [OW:0]  val_d [3];
  logic signed [OW:0]  lim_s;

  logic signed [OW-1:0] pos_q [3];
  logic                 sing_out_q;
  logic                 clip_out_q;

  assign pready = 1'b1;
  assign prdata = PDATA_W'(anchor_q[paddr[4:3]]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        anchor_q[k] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      anchor_q[paddr[4:3]] <= pwdata[AXW-1:0];
    end
  end

  assign en         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  assign range_d[0] = range_a_i;
  assign range_d[1] = range_b_i;
  assign range_d[2] = range_c_i;
  assign range_d[3] = range_d_i;

  trilat_geom u_geom (
    .clk_i    (clk_i),
    .en_i     (en),
    .anchor_i (anchor_q),
    .range_i  (range_d),
    .geo_o    (geo)
  );

  for (genvar k = 0; k < 3; k++) begin : g_lane
    trilat_div_lane #(
      .SAT_BITS (SAT_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (geo.num[k]),
      .dabs_i (geo.dabs),
      .quot_o (quot[k]),
      .neg_o  (neg[k]),
      .clip_o (clip[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q <= {sing_q[DIV_LAT-2:0], geo.sing};
    end
  end

  always_comb begin
    lim_s = (OW+1)'(1) <<< (SAT_BITS - 1);
    for (int k = 0; k < 3; k++) begin
      if (clip[k]) begin
        val_d[k] = neg[k] ? -lim_s : lim_s - (OW+1)'(1);
      end else begin
        val_d[k] = neg[k] ? -$signed((OW+1)'(quot[k])) : $signed((OW+1)'(quot[k]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_out_q <= sing_q[DIV_LAT-1];
      clip_out_q <= !sing_q[DIV_LAT-1] && (clip[0] || clip[1] || clip[2]);
      for (int k = 0; k < 3; k++) begin
        pos_q[k] <= sing_q[DIV_LAT-1] ? '0 : OW'(val_d[k]);
      end
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign pos_x_o     = pos_q[0];
  assign pos_y_o     = pos_q[1];
  assign pos_z_o     = pos_q[2];
  assign singular_o  = sing_out_q;
  assign clipped_o   = clip_out_q;

endmodule

[tb/tb.sv]
// Self-checking testbench for the four-anchor trilateration core with a position predictor.
module tb;
  import trilat_pkg::*;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               sing;
    logic               clip;
  } position_t;

  class position_scoreboard;
    logic [47:0] anchors[4];
    position_t   pending[$];
    int          errors;

    function new();
      for (int i = 0; i < 4; i++) anchors[i] = '0;
      errors = 0;
    endfunction

    function longint crd(int k, int c);
      logic signed [15:0] v;
      v = anchors[k][16*c +: 16];
      return longint'(v);
    endfunction

    function logic signed [15:0] saturate(logic signed [127:0] q, ref logic clip);
      if (q > 128'sd32767) begin
        clip = 1'b1;
        return 16'sh7fff;
      end
      if (q < -128'sd32768) begin
        clip = 1'b1;
        return 16'sh8000;
      end
      return q[15:0];
    endfunction

    function void note_request(logic [15:0] ra, logic [15:0] rb, logic [15:0] rc,
                               logic [15:0] rd);
      longint m[3][3], adj[3][3], w[3], rg[4], sq[4], det;
      logic signed [127:0] num, den;
      logic signed [15:0] p[3];
      position_t e;
      logic clip;
      rg[0] = longint'(ra); rg[1] = longint'(rb); rg[2] = longint'(rc); rg[3] = longint'(rd);
      for (int k = 0; k < 4; k++) begin
        sq[k] = 0;
        for (int c = 0; c < 3; c++) sq[k] += crd(k, c) * crd(k, c);
      end
      for (int k = 0; k < 3; k++) begin
        w[k] = rg[0] * rg[0] - rg[k+1] * rg[k+1] + sq[k+1] - sq[0];
        for (int c = 0; c < 3; c++) m[k][c] = crd(k + 1, c) - crd(0, c);
      end
      adj[0][0] = m[1][1] * m[2][2] - m[1][2] * m[2][1];
      adj[0][1] = m[0][2] * m[2][1] - m[0][1] * m[2][2];
      adj[0][2] = m[0][1] * m[1][2] - m[0][2] * m[1][1];
      adj[1][0] = m[1][2] * m[2][0] - m[1][0] * m[2][2];
      adj[1][1] = m[0][0] * m[2][2] - m[0][2] * m[2][0];
      adj[1][2] = m[0][2] * m[1][0] - m[0][0] * m[1][2];
      adj[2][0] = m[1][0] * m[2][1] - m[1][1] * m[2][0];
      adj[2][1] = m[0][1] * m[2][0] - m[0][0] * m[2][1];
      adj[2][2] = m[0][0] * m[1][1] - m[0][1] * m[1][0];
      det = m[0][0] * adj[0][0] + m[0][1] * adj[1][0] + m[0][2] * adj[2][0];
      clip = 1'b0;
      if (det == 0) begin
        e = '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0};
      end else begin
        den = 128'(2 * det);
        for (int k = 0; k < 3; k++) begin
          num = 0;
          for (int i = 0; i < 3; i++) num += 128'(adj[k][i]) * 128'(w[i]);
          p[k] = saturate(num / den, clip);
        end
        e = '{p[0], p[1], p[2], 1'b0, clip};
      end
      pending.push_back(e);
    endfunction

    function void check_result(position_t a);
      position_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d s=%0b c=%0b",
                 $time, a.x, a.y, a.z, a.sing, a.clip);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.x !== a.x || e.y !== a.y || e.z !== a.z || e.sing !== a.sing ||
          e.clip !== a.clip) begin
        $display("%0t: mismatch expected x=%0d y=%0d z=%0d s=%0b c=%0b",
                 $time, e.x, e.y, e.z, e.sing, e.clip);
        $display("%0t:          actual   x=%0d y=%0d z=%0d s=%0b c=%0b",
                 $time, a.x, a.y, a.z, a.sing, a.clip);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [15:0] range_a_i = '0, range_b_i = '0, range_c_i = '0, range_d_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] pos_x_o, pos_y_o, pos_z_o;
  logic singular_o, clipped_o;

  position_scoreboard sb = new();
  int  cycles = 0;
  bit  hold_done = 1'b0;
  bit  hold_armed = 1'b0;

  four_anchor_trilateration_core u_top (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{pos_x_o, pos_y_o, pos_z_o, singular_o, clipped_o});
  end

  initial begin : receiver
    int r;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_armed && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_done = 1'b1;
        out_stall_i <= 1'b0;
      end else begin
        r = $urandom_range(99);
        if (r < 3) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(60, 20)) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end else begin
          out_stall_i <= (r < 25);
        end
      end
    end
  end

  function automatic logic [47:0] pack_xyz(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  task automatic write_anchor(int idx, logic [47:0] val, logic [15:0] junk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(8 * idx);
    pwdata <= {junk, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.anchors[idx] = val;
  endtask

  task automatic load_anchors(logic [47:0] a, logic [47:0] b, logic [47:0] c,
                              logic [47:0] d);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    write_anchor(0, a, 16'($urandom));
    write_anchor(1, b, 16'($urandom));
    write_anchor(2, c, 16'($urandom));
    write_anchor(3, d, 16'($urandom));
  endtask

  task automatic send_ranges(logic [15:0] ra, logic [15:0] rb, logic [15:0] rc,
                             logic [15:0] rd);
    int r, gap;
    in_valid_i <= 1'b1;
    range_a_i <= ra;
    range_b_i <= rb;
    range_c_i <= rc;
    range_d_i <= rd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(ra, rb, rc, rd);
    r = $urandom_range(99);
    gap = (r < 65) ? 0 : (r < 96) ? $urandom_range(3, 1) : $urandom_range(60, 20);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [15:0] rand_range();
    int r;
    r = $urandom_range(9);
    if (r < 4) return 16'($urandom_range(20000));
    if (r < 5) return 16'($urandom_range(65535, 60000));
    return 16'($urandom);
  endfunction

  task automatic random_burst(int n);
    for (int i = 0; i < n; i++)
      send_ranges(rand_range(), rand_range(), rand_range(), rand_range());
  endtask

  initial begin : stimulus
    logic [47:0] ga[4];
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset anchors are all zero, so the geometry is singular.
    send_ranges(16'd0, 16'd0, 16'd0, 16'd0);
    send_ranges(16'hffff, 16'd1, 16'd2, 16'd3);

    load_anchors(pack_xyz(0, 0, 0), pack_xyz(10000, 0, 0), pack_xyz(0, 10000, 0),
                 pack_xyz(0, 0, 10000));
    send_ranges(16'd0, 16'd10000, 16'd10000, 16'd10000);
    send_ranges(16'd5000, 16'd5000, 16'd5000, 16'd5000);
    send_ranges(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_ranges(16'hffff, 16'd0, 16'd0, 16'd0);
    send_ranges(16'd0, 16'hffff, 16'hffff, 16'hffff);
    send_ranges(16'd0, 16'hffff, 16'd0, 16'd0);
    send_ranges(16'd0, 16'd0, 16'hffff, 16'd0);
    send_ranges(16'd0, 16'd0, 16'd0, 16'hffff);
    send_ranges(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    send_ranges(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    random_burst(150);

    load_anchors(pack_xyz(-32768, -32768, -32768), pack_xyz(32767, -32768, -32768),
                 pack_xyz(-32768, 32767, -32768), pack_xyz(-32768, -32768, 32767));
    send_ranges(16'd0, 16'd0, 16'd0, 16'd0);
    send_ranges(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_ranges(16'hffff, 16'd0, 16'd0, 16'd0);
    send_ranges(16'd0, 16'hffff, 16'hffff, 16'hffff);
    hold_armed = 1'b1;
    random_burst(150);

    load_anchors(pack_xyz(0, 0, 0), pack_xyz(1000, 0, 0), pack_xyz(0, 1000, 0),
                 pack_xyz(1000, 1000, 0));
    random_burst(60);

    load_anchors(pack_xyz(1, 0, 0), pack_xyz(0, 1, 0), pack_xyz(0, 0, 1),
                 pack_xyz(0, 0, 0));
    random_burst(120);

    for (int ph = 0; ph < 6; ph++) begin
      for (int k = 0; k < 4; k++) begin
        if (ph < 3) ga[k] = 48'({$urandom, $urandom});
        else ga[k] = pack_xyz($urandom_range(6000) - 3000, $urandom_range(6000) - 3000,
                              $urandom_range(6000) - 3000);
      end
      load_anchors(ga[0], ga[1], ga[2], ga[3]);
      random_burst(140);
    end

    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
